@@ rtl/dcss_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the drift correction step scheduler.
// No dependencies; used by the interfaces, controller, datapath and top level.
package dcss_pkg;

    localparam int OpW      = 2;
    localparam int CorrW    = 17;
    localparam int ElapW    = 16;
    localparam int StepW    = 2;
    localparam int PendW    = 32;
    localparam int SettleW  = 24;
    localparam int MaxW     = 16;
    localparam int CfgAddrW = 3;
    localparam int CfgDataW = 32;

    // restoring divider: one quotient bit per cycle over the settle width
    localparam int DivSteps = SettleW;
    localparam int DivCntW  = $clog2(DivSteps);

    localparam logic [SettleW-1:0] SettleReset = 24'd4800;
    localparam logic [MaxW-1:0]    MaxReset    = 16'd480;

    localparam logic signed [StepW-1:0] StepZero = 2'sb00;
    localparam logic signed [StepW-1:0] StepPos  = 2'sb01;
    localparam logic signed [StepW-1:0] StepNeg  = 2'sb11;

    typedef enum logic [OpW-1:0] {
        OP_QUEUE   = 2'd0,
        OP_ADVANCE = 2'd1,
        OP_RESTORE = 2'd2,
        OP_NONE    = 2'd3
    } t_op;

    typedef enum logic {
        REG_SETTLE = 1'b0,
        REG_MAX    = 1'b1
    } t_reg_idx;

    typedef struct packed {
        logic load;
        logic exec;
        logic div_step;
        logic div_finish;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic need_div;
        logic div_last;
    } t_stat;

endpackage

@@ rtl/dcss_ifs.sv @@
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the scheduler's item and result beats.
// Depends on dcss_pkg for field widths.
interface dcss_in_if;
    logic                                  valid;
    logic                                  ready;
    logic [dcss_pkg::OpW-1:0]              operation;
    logic signed [dcss_pkg::CorrW-1:0]     correction;
    logic [dcss_pkg::ElapW-1:0]            elapsed_frames;

    modport source (output valid, operation, correction, elapsed_frames, input ready);
    modport sink   (input valid, operation, correction, elapsed_frames, output ready);
endinterface

interface dcss_out_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [dcss_pkg::StepW-1:0]     step;
    logic signed [dcss_pkg::PendW-1:0]     pending_now;

    modport source (output valid, step, pending_now, input ready);
    modport sink   (input valid, step, pending_now, output ready);
endinterface

@@ rtl/dcss_ctrl.sv @@
`timescale 1ns / 1ps
// Sequencing controller: walks one item via execute, any divide, result.
// Depends on dcss_pkg for the command and status structs.
module dcss_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    input  dcss_pkg::t_stat  i_stat,
    output dcss_pkg::t_cmd   o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_DIV,
        S_FIN,
        S_RESULT
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   w_out_free;

    assign w_out_free  = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        o_cmd.load       = (r_state == S_IDLE) && i_in_valid;
        o_cmd.exec       = (r_state == S_EXEC);
        o_cmd.div_step   = (r_state == S_DIV);
        o_cmd.div_finish = (r_state == S_FIN);
        o_cmd.emit       = (r_state == S_RESULT) && w_out_free;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_EXEC;
            end
            S_EXEC: begin
                n_state = i_stat.need_div ? S_DIV : S_RESULT;
            end
            S_DIV: begin
                if (i_stat.div_last) n_state = S_FIN;
            end
            S_FIN: begin
                n_state = S_RESULT;
            end
            S_RESULT: begin
                // hold until the output register frees up
                if (w_out_free) n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        if (o_cmd.emit) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

@@ rtl/dcss_dp.sv @@
`timescale 1ns / 1ps
// Datapath: config registers, scheduler state, restoring divider, result register.
// Depends on dcss_pkg; driven by dcss_ctrl commands.
module dcss_dp (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  dcss_pkg::t_cmd                        i_cmd,
    output dcss_pkg::t_stat                       o_stat,
    input  logic [dcss_pkg::OpW-1:0]              i_operation,
    input  logic signed [dcss_pkg::CorrW-1:0]     i_correction,
    input  logic [dcss_pkg::ElapW-1:0]            i_elapsed_frames,
    input  logic                                  i_cfg_we,
    input  logic                                  i_cfg_sel,
    input  logic [dcss_pkg::CfgDataW-1:0]         i_cfg_wdata,
    output logic [dcss_pkg::CfgDataW-1:0]         o_cfg_rdata,
    output logic signed [dcss_pkg::StepW-1:0]     o_step,
    output logic signed [dcss_pkg::PendW-1:0]     o_pending_now
);

    localparam int SW = dcss_pkg::SettleW;
    localparam int MW = dcss_pkg::MaxW;
    localparam int PW = dcss_pkg::PendW;
    localparam int CW = dcss_pkg::CorrW;
    localparam int EW = dcss_pkg::ElapW;
    localparam int SumW = PW + 2;
    localparam logic [dcss_pkg::DivCntW-1:0] DivLast =
        dcss_pkg::DivCntW'(dcss_pkg::DivSteps - 1);

    // control state
    logic [SW-1:0]            r_settle, n_settle;
    logic [MW-1:0]            r_max, n_max;
    logic [PW-1:0]            r_pending, n_pending;
    logic [SW-1:0]            r_interval, n_interval;
    logic [SW-1:0]            r_countdown, n_countdown;
    logic [dcss_pkg::DivCntW-1:0] r_cnt, n_cnt;

    // payload
    dcss_pkg::t_op            r_op;
    logic signed [CW-1:0]     r_corr;
    logic [EW-1:0]            r_elapsed;
    logic signed [dcss_pkg::StepW-1:0] r_step, n_step;
    logic [MW-1:0]            r_rem, n_rem;
    logic [SW-1:0]            r_quo, n_quo;
    logic [MW-1:0]            r_divisor, n_divisor;
    logic signed [dcss_pkg::StepW-1:0] r_out_step;
    logic [PW-1:0]            r_out_pending;

    // queue path
    logic signed [SumW-1:0]   w_sum, w_lim, w_nlim, w_clamp, w_neg;
    logic [MW-1:0]            w_mag;
    logic                     w_q_active;
    logic [SW-1:0]            w_settle_eff;
    // advance path
    logic                     w_adv_active;
    logic [SW-1:0]            w_elap_ext;
    logic [EW-1:0]            w_over;
    logic [SW-1:0]            w_ivl_eff;
    logic [PW-1:0]            w_pend_step;
    // restore path
    logic [PW-1:0]            w_rest;
    // divider
    logic [MW:0]              w_rem_sh;
    logic                     w_ge;
    logic [MW:0]              w_rem_sub;
    logic [SW-1:0]            w_q_eff;

    assign w_sum = $signed({{2{r_pending[PW-1]}}, r_pending})
                 + $signed({{(SumW-CW){r_corr[CW-1]}}, r_corr});
    assign w_lim  = $signed({{(SumW-MW){1'b0}}, r_max});
    assign w_nlim = -w_lim;

    always_comb begin
        if (w_sum > w_lim) begin
            w_clamp = w_lim;
        end else if (w_sum < w_nlim) begin
            w_clamp = w_nlim;
        end else begin
            w_clamp = w_sum;
        end
    end

    assign w_neg        = -w_clamp;
    assign w_mag        = w_clamp[SumW-1] ? w_neg[MW-1:0] : w_clamp[MW-1:0];
    assign w_q_active   = (r_corr != '0) && (r_max != '0);
    assign w_settle_eff = (r_settle == '0) ? SW'(1) : r_settle;

    assign w_adv_active = (r_pending != '0) && (r_elapsed != '0);
    assign w_elap_ext   = {{(SW-EW){1'b0}}, r_elapsed};
    assign w_over       = r_elapsed - r_countdown[EW-1:0];
    assign w_ivl_eff    = (r_interval == '0) ? SW'(1) : r_interval;
    assign w_pend_step  = r_pending[PW-1] ? r_pending + PW'(1) : r_pending - PW'(1);

    assign w_rest = r_pending + {{(PW-CW){r_corr[CW-1]}}, r_corr};

    assign w_rem_sh  = {r_rem, r_quo[SW-1]};
    assign w_ge      = w_rem_sh >= {1'b0, r_divisor};
    assign w_rem_sub = w_rem_sh - {1'b0, r_divisor};
    assign w_q_eff   = (r_quo == '0) ? SW'(1) : r_quo;

    assign o_stat.need_div = (r_op == dcss_pkg::OP_QUEUE) && w_q_active && (w_mag != '0);
    assign o_stat.div_last = (r_cnt == DivLast);

    assign o_cfg_rdata = (i_cfg_sel == dcss_pkg::REG_MAX)
                       ? {{(dcss_pkg::CfgDataW-MW){1'b0}}, r_max}
                       : {{(dcss_pkg::CfgDataW-SW){1'b0}}, r_settle};

    assign o_step        = r_out_step;
    assign o_pending_now = r_out_pending;

    always_comb begin
        n_settle    = r_settle;
        n_max       = r_max;
        n_pending   = r_pending;
        n_interval  = r_interval;
        n_countdown = r_countdown;
        n_cnt       = r_cnt;
        n_step      = r_step;
        n_rem       = r_rem;
        n_quo       = r_quo;
        n_divisor   = r_divisor;

        if (i_cfg_we) begin
            if (i_cfg_sel == dcss_pkg::REG_MAX) begin
                n_max = i_cfg_wdata[MW-1:0];
            end else begin
                n_settle = i_cfg_wdata[SW-1:0];
            end
        end

        if (i_cmd.exec) begin
            n_step = dcss_pkg::StepZero;
            case (r_op)
                dcss_pkg::OP_QUEUE: begin
                    if (w_q_active) begin
                        n_pending = w_clamp[PW-1:0];
                        if (w_mag == '0) begin
                            n_interval  = '0;
                            n_countdown = '0;
                        end else begin
                            n_rem     = '0;
                            n_quo     = w_settle_eff;
                            n_divisor = w_mag;
                            n_cnt     = '0;
                        end
                    end
                end
                dcss_pkg::OP_ADVANCE: begin
                    if (w_adv_active) begin
                        if (r_countdown > w_elap_ext) begin
                            n_countdown = r_countdown - w_elap_ext;
                        end else begin
                            n_step    = r_pending[PW-1] ? dcss_pkg::StepNeg : dcss_pkg::StepPos;
                            n_pending = w_pend_step;
                            if (w_pend_step == '0) begin
                                n_countdown = '0;
                                n_interval  = '0;
                            end else if (w_ivl_eff > {{(SW-EW){1'b0}}, w_over}) begin
                                // carry the overshoot into the next countdown
                                n_countdown = w_ivl_eff - {{(SW-EW){1'b0}}, w_over};
                            end else begin
                                n_countdown = SW'(1);
                            end
                        end
                    end
                end
                dcss_pkg::OP_RESTORE: begin
                    if (r_corr != '0) begin
                        n_pending   = w_rest;
                        n_countdown = w_ivl_eff;
                    end
                end
                default: begin
                end
            endcase
        end

        if (i_cmd.div_step) begin
            n_rem = w_ge ? w_rem_sub[MW-1:0] : w_rem_sh[MW-1:0];
            n_quo = {r_quo[SW-2:0], w_ge};
            n_cnt = r_cnt + dcss_pkg::DivCntW'(1);
        end

        if (i_cmd.div_finish) begin
            n_interval = w_q_eff;
            // pull the countdown in when it is idle or too long
            if ((r_countdown == '0) || (r_countdown > w_q_eff)) begin
                n_countdown = w_q_eff;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_settle    <= dcss_pkg::SettleReset;
            r_max       <= dcss_pkg::MaxReset;
            r_pending   <= '0;
            r_interval  <= '0;
            r_countdown <= '0;
            r_cnt       <= '0;
        end else begin
            r_settle    <= n_settle;
            r_max       <= n_max;
            r_pending   <= n_pending;
            r_interval  <= n_interval;
            r_countdown <= n_countdown;
            r_cnt       <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op      <= dcss_pkg::t_op'(i_operation);
            r_corr    <= i_correction;
            r_elapsed <= i_elapsed_frames;
        end
        if (i_cmd.emit) begin
            r_out_step    <= r_step;
            r_out_pending <= r_pending;
        end
        r_step    <= n_step;
        r_rem     <= n_rem;
        r_quo     <= n_quo;
        r_divisor <= n_divisor;
    end

endmodule

@@ rtl/drift_correction_step_scheduler_core.sv @@
`timescale 1ns / 1ps
// Top level of the drift correction step scheduler: controller plus datapath.
// Depends on dcss_pkg, dcss_ifs, dcss_ctrl and dcss_dp.
//
//  channel   dir  handshake             payload
//  i_item    in   valid / ready         operation, correction, elapsed_frames
//  o_result  out  valid / ready         step, pending_now
//  apb       in   psel, penable, pready pwrite, paddr, pwdata, prdata
//
// A queue item with a nonzero clamped pending count goes through the restoring
// divider (one quotient bit a cycle) before its result; all other items go
// straight from execute to result.
// One result beat per item; the output register lets the next item be taken
// while a result waits. A stalled result holds the item after it at its last
// step. Reset is synchronous and active low.
module drift_correction_step_scheduler_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    dcss_in_if.sink                             i_item,
    dcss_out_if.source                          o_result,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [dcss_pkg::CfgAddrW-1:0]       paddr,
    input  logic [dcss_pkg::CfgDataW-1:0]       pwdata,
    output logic [dcss_pkg::CfgDataW-1:0]       prdata,
    output logic                                pready
);

    dcss_pkg::t_cmd  w_cmd;
    dcss_pkg::t_stat w_stat;
    logic            w_cfg_we;

    assign pready   = 1'b1;
    assign w_cfg_we = psel && penable && pwrite;

    dcss_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_item.valid),
        .o_in_ready  (i_item.ready),
        .o_out_valid (o_result.valid),
        .i_out_ready (o_result.ready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    dcss_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .o_stat           (w_stat),
        .i_operation      (i_item.operation),
        .i_correction     (i_item.correction),
        .i_elapsed_frames (i_item.elapsed_frames),
        .i_cfg_we         (w_cfg_we),
        .i_cfg_sel        (paddr[2]),
        .i_cfg_wdata      (pwdata),
        .o_cfg_rdata      (prdata),
        .o_step           (o_result.step),
        .o_pending_now    (o_result.pending_now)
    );

endmodule

@@ rtl/dcss_chk.sv @@
`timescale 1ns / 1ps
// Port-level checker for the scheduler top level, attached by bind.
// Depends on dcss_pkg for widths.
module dcss_chk (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                i_in_valid,
    input logic                                i_in_ready,
    input logic                                i_out_valid,
    input logic                                i_out_ready,
    input logic signed [dcss_pkg::StepW-1:0]   i_out_step,
    input logic signed [dcss_pkg::PendW-1:0]   i_out_pending
);

    // a stalled result beat stays up
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result beat dropped while stalled");

    // a stalled result beat keeps its payload
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_out_step) && $stable(i_out_pending))
        else $error("result payload changed while stalled");

    // step is only ever -1, 0 or +1
    a_step_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_out_step != 2'sb10))
        else $error("step carries an illegal code");

    // one item in flight: no accept in the cycle after an accept
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("second item taken while one is in flight");

    // reset leaves the block ready with no result pending
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> i_in_ready && !i_out_valid)
        else $error("block not idle after reset");

endmodule

bind drift_correction_step_scheduler_core dcss_chk u_dcss_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_item.valid),
    .i_in_ready    (i_item.ready),
    .i_out_valid   (o_result.valid),
    .i_out_ready   (o_result.ready),
    .i_out_step    (o_result.step),
    .i_out_pending (o_result.pending_now)
);

@@ sim/drift_correction_step_scheduler_core_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for drift_correction_step_scheduler_core: a directed pass, then
// random queue/advance/restore traffic under several settle/limit settings, with random stalls.
// Depends on dcss_pkg, dcss_ifs and the scheduler RTL.
module drift_correction_step_scheduler_core_tb;
    import dcss_pkg::*;

    typedef struct packed {
        logic signed [StepW-1:0] step;
        logic signed [PendW-1:0] pend;
    } t_drift_result;

    typedef struct {
        t_op op;
        int  corr;
        int  elap;
    } t_drift_item;

    typedef struct {
        int unsigned settle;
        int unsigned limit;
        int          count;
    } t_phase;

    // Tracks pending corrections, the step spacing and the frame countdown,
    // and holds the result each accepted beat should produce.
    class drift_scoreboard;
        logic [SettleW-1:0] settle_len;
        logic [MaxW-1:0]    pend_limit;
        logic [PendW-1:0]   pend_cnt;
        logic [PendW-1:0]   step_gap;
        logic [PendW-1:0]   frames_left;
        t_drift_result      expected_steps[$];
        int                 errors;

        function new();
            settle_len  = SettleReset;
            pend_limit  = MaxReset;
            pend_cnt    = '0;
            step_gap    = '0;
            frames_left = '0;
            errors      = 0;
        endfunction

        function void write_reg(t_reg_idx idx, logic [CfgDataW-1:0] value);
            if (idx == REG_SETTLE)
                settle_len = value[SettleW-1:0];
            else
                pend_limit = value[MaxW-1:0];
        endfunction

        function void accept_item(t_op op, logic signed [CorrW-1:0] corr,
                                  logic [ElapW-1:0] elap);
            longint                  sum;
            longint                  lim;
            logic [PendW-1:0]        mag;
            logic [PendW-1:0]        quot;
            logic [PendW-1:0]        over;
            logic [PendW-1:0]        base;
            logic signed [StepW-1:0] step_now;
            step_now = StepZero;
            case (op)
                OP_QUEUE: begin
                    if (corr != 0 && pend_limit != 0) begin
                        lim = longint'(pend_limit);
                        sum = longint'($signed(pend_cnt)) + longint'(corr);
                        if (sum > lim)
                            sum = lim;
                        else if (sum < -lim)
                            sum = -lim;
                        pend_cnt = sum[PendW-1:0];
                        mag = pend_cnt[PendW-1] ? -pend_cnt : pend_cnt;
                        if (mag == 0) begin
                            step_gap    = '0;
                            frames_left = '0;
                        end else begin
                            quot = (settle_len == 0 ? 32'd1 : 32'(settle_len)) / mag;
                            step_gap = (quot == 0) ? 32'd1 : quot;
                            if (frames_left == 0 || frames_left > step_gap)
                                frames_left = step_gap;
                        end
                    end
                end
                OP_ADVANCE: begin
                    if (pend_cnt != 0 && elap != 0) begin
                        if (frames_left > 32'(elap)) begin
                            frames_left = frames_left - 32'(elap);
                        end else begin
                            over = 32'(elap) - frames_left;
                            // step toward zero pending
                            if (pend_cnt[PendW-1]) begin
                                step_now = StepNeg;
                                pend_cnt = pend_cnt + 1;
                            end else begin
                                step_now = StepPos;
                                pend_cnt = pend_cnt - 1;
                            end
                            if (pend_cnt == 0) begin
                                frames_left = '0;
                                step_gap    = '0;
                            end else begin
                                base = (step_gap != 0) ? step_gap : 32'd1;
                                frames_left = (base > over) ? base - over : 32'd1;
                            end
                        end
                    end
                end
                OP_RESTORE: begin
                    if (corr != 0) begin
                        pend_cnt    = pend_cnt + 32'(corr);
                        frames_left = (step_gap != 0) ? step_gap : 32'd1;
                    end
                end
                default: ;
            endcase
            expected_steps.push_back('{step: step_now, pend: pend_cnt});
        endfunction

        function void check_result(logic signed [StepW-1:0] step,
                                   logic signed [PendW-1:0] pend);
            t_drift_result want;
            if (expected_steps.size() == 0) begin
                $display("%0t: unexpected result beat, step %0d pending %0d",
                         $time, step, pend);
                errors++;
                return;
            end
            want = expected_steps.pop_front();
            if (step !== want.step) begin
                $display("%0t: step mismatch, expected %0d, actual %0d",
                         $time, want.step, step);
                errors++;
            end
            if (pend !== want.pend) begin
                $display("%0t: pending_now mismatch, expected %0d, actual %0d",
                         $time, want.pend, pend);
                errors++;
            end
        endfunction
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [CfgAddrW-1:0] paddr;
    logic [CfgDataW-1:0] pwdata;
    logic [CfgDataW-1:0] prdata;
    logic               pready;
    bit                 no_stall;

    dcss_in_if  item_if ();
    dcss_out_if result_if ();

    drift_scoreboard sb;

    drift_correction_step_scheduler_core u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (item_if),
        .o_result (result_if),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    t_drift_item directed_items [20] = '{
        '{OP_NONE,    0,      0},
        '{OP_ADVANCE, 0,      100},
        '{OP_QUEUE,   0,      0},
        '{OP_QUEUE,   65535,  0},
        '{OP_ADVANCE, 0,      0},
        '{OP_ADVANCE, 0,      9},
        '{OP_ADVANCE, 0,      65535},
        '{OP_RESTORE, 0,      0},
        '{OP_RESTORE, 1,      0},
        '{OP_QUEUE,   -65536, 0},
        '{OP_ADVANCE, 0,      12},
        '{OP_QUEUE,   479,    0},
        '{OP_QUEUE,   1,      0},
        '{OP_ADVANCE, 0,      4800},
        '{OP_QUEUE,   -1,     0},
        '{OP_RESTORE, -65536, 0},
        '{OP_ADVANCE, 0,      65535},
        '{OP_QUEUE,   2,      0},
        '{OP_NONE,    -1,     65535},
        '{OP_RESTORE, 65535,  0}
    };

    t_phase phases [6] = '{
        '{48,       16,    90},
        '{0,        65535, 80},
        '{16777215, 1,     80},
        '{1000,     0,     50},
        '{0,        0,     100},
        '{4800,     480,   100}
    };

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("TEST FAILED");
        $finish;
    end

    // result side: check every accepted beat, stall at random
    initial begin
        result_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && result_if.valid && result_if.ready)
                sb.check_result(result_if.step, result_if.pending_now);
            result_if.ready <= no_stall || ($urandom_range(99) >= 19);
        end
    end

    task automatic send_item(t_op op, logic signed [CorrW-1:0] corr, logic [ElapW-1:0] elap);
        if (!no_stall) begin
            while ($urandom_range(99) < 19) begin
                item_if.valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        item_if.valid          <= 1'b1;
        item_if.operation      <= op;
        item_if.correction     <= corr;
        item_if.elapsed_frames <= elap;
        @(posedge i_clk);
        while (!item_if.ready)
            @(posedge i_clk);
        sb.accept_item(op, corr, elap);
    endtask

    task automatic wait_results_drained();
        while (sb.expected_steps.size() != 0)
            @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic cfg_write(t_reg_idx idx, logic [CfgDataW-1:0] value);
        logic [CfgDataW-1:0] mask;
        mask = (idx == REG_SETTLE) ? 32'h00FF_FFFF : 32'h0000_FFFF;
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready)
            @(posedge i_clk);
        sb.write_reg(idx, value);
        // turn the same select into a read-back
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready)
            @(posedge i_clk);
        if (prdata !== (value & mask)) begin
            $display("%0t: register %0d read-back mismatch, expected %0h, actual %0h",
                     $time, idx, value & mask, prdata);
            sb.errors++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Mostly small corrections and elapsed counts near the live countdown, so steps
    // actually fire; the rest is full-range noise and field extremes.
    function automatic void draw_drift_item(output t_op op,
                                            output logic signed [CorrW-1:0] corr,
                                            output logic [ElapW-1:0] elap);
        int unsigned pick;
        int unsigned span;
        pick = $urandom_range(99);
        op = (pick < 30) ? OP_QUEUE : (pick < 78) ? OP_ADVANCE :
             (pick < 92) ? OP_RESTORE : OP_NONE;
        pick = $urandom_range(9);
        if (op == OP_RESTORE && pick < 6)
            corr = pick[0] ? 17'sd1 : -17'sd1;
        else if (pick < 6)
            corr = 17'($signed($urandom_range(40)) - 20);
        else if (pick < 8)
            corr = 17'($urandom);
        else if (pick == 8)
            corr = $urandom_range(1) ? 17'h10000 : 17'h0FFFF;
        else
            corr = '0;
        span = (sb.frames_left != 0 && sb.frames_left < 32768) ? 2 * sb.frames_left : 200;
        pick = $urandom_range(9);
        if (pick < 6)
            elap = 16'($urandom_range(span));
        else if (pick < 8)
            elap = 16'($urandom);
        else if (pick == 8)
            elap = '0;
        else
            elap = 16'hFFFF;
    endfunction

    initial begin
        t_op                     op;
        logic signed [CorrW-1:0] corr;
        logic [ElapW-1:0]        elap;
        t_phase                  ph;

        sb = new();
        no_stall               = 1'b0;
        i_rst_n                <= 1'b0;
        psel                   <= 1'b0;
        penable                <= 1'b0;
        pwrite                 <= 1'b0;
        paddr                  <= '0;
        pwdata                 <= '0;
        item_if.valid          <= 1'b0;
        item_if.operation      <= OP_NONE;
        item_if.correction     <= '0;
        item_if.elapsed_frames <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed pass on the reset settings
        foreach (directed_items[k])
            send_item(directed_items[k].op, 17'(directed_items[k].corr),
                      16'(directed_items[k].elap));
        item_if.valid <= 1'b0;
        wait_results_drained();

        foreach (phases[p]) begin
            ph = phases[p];
            if (p == 4) begin
                ph.settle = $urandom_range(20000, 1);
                ph.limit  = $urandom_range(2000, 1);
            end
            cfg_write(REG_SETTLE, ph.settle);
            cfg_write(REG_MAX, ph.limit);
            no_stall = (p == 1);
            for (int n = 0; n < ph.count; n++) begin
                draw_drift_item(op, corr, elap);
                send_item(op, corr, elap);
                // one phase pauses halfway until every outstanding result is back
                if (p == 4 && n == ph.count / 2) begin
                    item_if.valid <= 1'b0;
                    while (sb.expected_steps.size() != 0)
                        @(posedge i_clk);
                end
            end
            item_if.valid <= 1'b0;
            wait_results_drained();
        end
        no_stall = 1'b0;

        if (sb.errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

@@ drift_correction_step_scheduler_core.f @@
rtl/dcss_pkg.sv
rtl/dcss_ifs.sv
rtl/dcss_ctrl.sv
rtl/dcss_dp.sv
rtl/drift_correction_step_scheduler_core.sv
rtl/dcss_chk.sv
sim/drift_correction_step_scheduler_core_tb.sv
